// ===== rtl/core/hrc_pkg.sv =====
// shared types and constants for the hamming radius count core
`default_nettype none

package hrc_pkg;

  localparam int MaxEntries = 16;
  localparam int VectorBits = 64;

  localparam int IdxW   = 4;   // entry index / load slot width
  localparam int CntW   = 5;   // entry count, 0 .. MaxEntries
  localparam int DistW  = 7;   // distance, 0 .. VectorBits
  localparam int FitW   = 5;   // signed fitness
  localparam int RadW   = 7;   // radius register
  localparam int LaneW  = 8;   // popcount lane width
  localparam int NumLanes = VectorBits / LaneW;
  localparam int LaneCntW = 4; // 0 .. LaneW

  localparam int InDataW  = 72; // slot + vector, padded to bytes
  localparam int OutDataW = 24; // index + distance + flag + fitness, padded
  localparam int CfgDataW = 7;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_RADIUS    = 1'b0,
    REG_SET_COUNT = 1'b1
  } reg_e;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_ISSUE = 1'b1
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/hamming_radius_count_core.sv =====
// hamming radius count core: reference store, compare sequencer and popcount pipeline
//
// usage
//   s_axis: one item per handshake. tuser is the operation, tdata holds the
//   store slot and the bit vector. a load writes the vector into its slot and
//   gives no result. an eval compares the vector with entries 0 .. set_count-1
//   (set_count saturates at 16) and gives one result item per entry on m_axis,
//   tlast marking the final one, which also carries the fitness (negated
//   count of entries within the radius).
//   cfg: index 0 = radius, index 1 = set_count; to be written while the core idles (the core does not enforce this).
//   throughput: after an eval is taken the input side stays low while the
//   sequencer issues the n compares (n = set_count clipped to 16), one compare
//   per cycle over the single store read port while the output does not stall; a load does not block the input.
//   pipeline: from issue a compare passes the store read, xor + lane popcount,
//   sum + radius compare and output registers, in that order, to reach m_axis.
//   reset: control clears, radius = 0, set_count = 16; the store holds
//   nothing meaningful until loaded.
//   stall: when m_axis_tready is low with a result waiting, the whole pipe and the
//   issuing sequencer freeze (an idle core still takes items); nothing is dropped or repeated.
`default_nettype none

module hamming_radius_count_core
  import hrc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // entry_slot[3:0], bit_vector[67:4], zero pad
  input  wire logic                s_axis_tuser,  // operation
  // result items
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // entry_index[3:0], distance[10:4],
                                                  // within_radius[11], fitness[16:12], zero pad
  output logic                     m_axis_tlast,  // last
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [RadW-1:0] radius_q;
  logic [CntW-1:0] set_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= '0;
      set_count_q <= CntW'(MaxEntries);
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_RADIUS:    radius_q    <= cfg_data_i[RadW-1:0];
        REG_SET_COUNT: set_count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input unpack and pipe advance
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]       in_slot;
  logic [VectorBits-1:0] in_vec;
  logic                  in_acc;
  logic                  adv;     // whole pipe moves one step
  logic                  out_v_q;

  assign in_slot = s_axis_tdata[IdxW-1:0];
  assign in_vec  = s_axis_tdata[IdxW +: VectorBits];
  assign adv     = !out_v_q || m_axis_tready;

  // set_count clipped to the store depth
  logic [CntW-1:0] n_sat;
  assign n_sat = (set_count_q > CntW'(MaxEntries)) ? CntW'(MaxEntries) : set_count_q;

  // ---------------------------------------------------------------------------
  // sequencer: walks entries 0 .. n-1, one compare per advancing cycle
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       last_idx_q, last_idx_d;
  logic [VectorBits-1:0] cand_q, cand_d;
  logic                  issue;
  logic                  issue_last;

  assign issue_last = (idx_q == last_idx_q);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    last_idx_d    = last_idx_q;
    cand_d        = cand_q;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    in_acc        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        in_acc        = s_axis_tvalid;
        // an eval with an empty set gives nothing and stays idle
        if (s_axis_tvalid && (op_e'(s_axis_tuser) == OP_EVAL) && (n_sat != '0)) begin
          state_d    = ST_ISSUE;
          idx_d      = '0;
          last_idx_d = IdxW'(n_sat - CntW'(1));
          cand_d     = in_vec;
        end
      end
      ST_ISSUE: begin
        issue = adv;
        if (adv) begin
          idx_d = idx_q + IdxW'(1);
          if (issue_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    cand_q     <= cand_d;
  end

  // ---------------------------------------------------------------------------
  // reference store: written by load items, read once per issue
  // ---------------------------------------------------------------------------
  logic [VectorBits-1:0] store_mem [MaxEntries];
  logic [VectorBits-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_e'(s_axis_tuser) == OP_LOAD)) begin
      store_mem[in_slot] <= in_vec;
    end
    if (issue) begin
      rd1_q <= store_mem[idx_q];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: store read data, candidate, tags
  // ---------------------------------------------------------------------------
  logic                  v1_q;
  logic [VectorBits-1:0] cand1_q;
  logic [IdxW-1:0]       idx1_q;
  logic                  last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cand1_q <= cand_q;
      idx1_q  <= idx_q;
      last1_q <= issue_last;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: xor and per-lane popcount
  // ---------------------------------------------------------------------------
  function automatic logic [LaneCntW-1:0] lane_pop(input logic [LaneW-1:0] b);
    logic [LaneCntW-1:0] c;
    c = '0;
    for (int k = 0; k < LaneW; k++) begin
      c = c + LaneCntW'(b[k]);
    end
    return c;
  endfunction

  logic [VectorBits-1:0] diff1;
  logic                  v2_q;
  logic [LaneCntW-1:0]   lane2_q [NumLanes];
  logic [IdxW-1:0]       idx2_q;
  logic                  last2_q;

  assign diff1 = rd1_q ^ cand1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      for (int l = 0; l < NumLanes; l++) begin
        lane2_q[l] <= lane_pop(diff1[l*LaneW +: LaneW]);
      end
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: lane sum and radius compare
  // ---------------------------------------------------------------------------
  logic [DistW-1:0] dist2;
  logic             v3_q;
  logic [DistW-1:0] dist3_q;
  logic             hit3_q;
  logic [IdxW-1:0]  idx3_q;
  logic             last3_q;

  always_comb begin
    dist2 = '0;
    for (int l = 0; l < NumLanes; l++) begin
      dist2 = dist2 + DistW'(lane2_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      dist3_q <= dist2;
      hit3_q  <= (dist2 <= radius_q);
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register and covered-count accumulator
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  cov_q, cov_d;
  logic [CntW-1:0]  cov_sum;
  logic [IdxW-1:0]  o_idx_q;
  logic [DistW-1:0] o_dist_q;
  logic             o_hit_q;
  logic [FitW-1:0]  o_fit_q;
  logic             o_last_q;

  assign cov_sum = cov_q + CntW'(hit3_q);
  assign cov_d   = last3_q ? '0 : cov_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      cov_q   <= '0;
    end else if (adv) begin
      out_v_q <= v3_q;
      if (v3_q) begin
        cov_q <= cov_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      o_idx_q  <= idx3_q;
      o_dist_q <= dist3_q;
      o_hit_q  <= hit3_q;
      o_fit_q  <= last3_q ? FitW'(CntW'(0) - cov_sum) : '0;
      o_last_q <= last3_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {(OutDataW - IdxW - DistW - 1 - FitW)'(0),
                          o_fit_q, o_hit_q, o_dist_q, o_idx_q};

`ifndef SYNTHESIS
  // an eval with entries to compare starts the walk at entry zero
  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && (n_sat != '0))
    |=> (state_q == ST_ISSUE) && (idx_q == '0))
    else $error("eval did not start the compare walk");

  // the walk never runs past the last entry of the run
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (idx_q <= last_idx_q))
    else $error("compare index ran past the last entry");

  // earlier results of a run carry zero fitness
  a_fit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !o_last_q) |-> (o_fit_q == '0))
    else $error("fitness set on a result that is not the last");

  // distance cannot exceed the vector width
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (o_dist_q <= DistW'(VectorBits)))
    else $error("distance out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/hamming_radius_count_core_tb.sv =====
// self-checking testbench for the hamming radius count core: load/eval stream, scoreboard
`default_nettype none

module hamming_radius_count_core_tb;
  import hrc_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no handshake at all before giving up
  localparam int DrainWait  = 8;     // pipe latency plus margin before a config write
  localparam int HoldCycles = 120;   // long receiver hold-off to back the pipe up

  // one compare result as the core reports it
  typedef struct packed {
    logic [IdxW-1:0]  entry_index;
    logic [DistW-1:0] distance;
    logic             in_radius;
    logic [FitW-1:0]  fitness;
    logic             last;
  } compare_t;

  // mirrors the reference store and registers, queues the compare results each eval causes
  class radius_count_scoreboard;
    logic [VectorBits-1:0] ref_vectors [MaxEntries];
    logic [RadW-1:0]       radius    = '0;
    logic [CntW-1:0]       set_count = CntW'(MaxEntries);
    compare_t              pending_compares [$];
    int                    mismatches = 0;

    function void note_config(reg_e idx, logic [CfgDataW-1:0] val);
      if (idx == REG_RADIUS) radius = val[RadW-1:0];
      else set_count = val[CntW-1:0];
    endfunction

    function void note_item(op_e op, logic [IdxW-1:0] slot, logic [VectorBits-1:0] vec);
      int       n;
      int       covered;
      compare_t c;
      if (op == OP_LOAD) begin
        ref_vectors[slot] = vec;
        return;
      end
      // counts above the store depth saturate, zero gives nothing
      n = (set_count > MaxEntries) ? MaxEntries : int'(set_count);
      covered = 0;
      for (int i = 0; i < n; i++) begin
        c.entry_index = IdxW'(i);
        c.distance    = DistW'($countones(ref_vectors[i] ^ vec));
        c.in_radius   = (c.distance <= radius);
        covered      += c.in_radius;
        c.last        = (i == n - 1);
        c.fitness     = c.last ? FitW'(-covered) : '0;
        pending_compares.push_back(c);
      end
    endfunction

    function void check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic last_flag);
      compare_t c;
      if (pending_compares.size() == 0) begin
        $error("unexpected result item: entry_index %0d distance %0d", data[3:0], data[10:4]);
        mismatches++;
        return;
      end
      c = pending_compares.pop_front();
      check_field("entry_index", c.entry_index, data[3:0]);
      check_field("distance", c.distance, data[10:4]);
      check_field("within_radius", c.in_radius, data[11]);
      check_field("fitness", $signed(c.fitness), $signed(data[16:12]));
      check_field("last", c.last, last_flag);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // entry_slot[3:0], bit_vector[67:4], zero pad
  logic                s_axis_tuser;   // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // entry_index, distance, within_radius, fitness
  logic                m_axis_tlast;   // last
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  radius_count_scoreboard sb = new();

  bit src_fast;        // sender offers back to back
  bit sink_fast;       // receiver adds no random gaps
  int sink_hold = 0;   // pending long hold-off request for the receiver

  hamming_radius_count_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // handshakes are judged on the values seen just before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.note_config(reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(op_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[67:4]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // result side: random gaps per item, plus the long hold-off when asked
  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end
      gap = sink_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [VectorBits-1:0] rand_vec();
    return {$urandom, $urandom};
  endfunction

  // offers one item; tvalid stays high afterwards so back-to-back items need no gap
  task automatic send_item(input op_e op, input logic [IdxW-1:0] slot,
                           input logic [VectorBits-1:0] vec);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, vec, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every expected result is in, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_compares.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic configure(input logic [RadW-1:0] rad, input logic [CntW-1:0] cnt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_RADIUS;
    cfg_data_i  <= rad;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_SET_COUNT;
    cfg_data_i  <= CfgDataW'(cnt);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    int                    pick;
    int                    flips;
    logic [VectorBits-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // reloads keep the store changing under the evals
      v = (pick < 3) ? '0 : (pick < 6) ? '1 : rand_vec();
      send_item(OP_LOAD, IdxW'($urandom_range(0, 15)), v);
    end else begin
      pick = $urandom_range(0, 9);
      v = sb.ref_vectors[$urandom_range(0, 15)];
      if (pick < 5) begin
        // candidate near a stored vector so distances land around the radius
        flips = $urandom_range(0, 40);
        repeat (flips) v[$urandom_range(0, 63)] ^= 1'b1;
      end else if (pick < 8) v = rand_vec();
      else if (pick == 8) v = '0;
      else v = '1;
      send_item(OP_EVAL, IdxW'($urandom_range(0, 15)), v);
    end
  endtask

  task automatic run_phase(input logic [RadW-1:0] rad, input logic [CntW-1:0] cnt,
                           input int n_items, input bit pressure);
    drain();
    configure(rad, cnt);
    src_fast  = ($urandom_range(0, 3) == 0);
    sink_fast = ($urandom_range(0, 3) == 0);
    if (pressure) begin
      src_fast  = 1'b1;
      sink_hold = HoldCycles;
    end
    repeat (n_items) random_item();
  endtask

  initial begin : stimulus
    logic [VectorBits-1:0] seed_vec [MaxEntries];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_RADIUS;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill every slot, the first six with corner patterns, then evaluate
    foreach (seed_vec[i]) seed_vec[i] = rand_vec();
    seed_vec[0] = '0;
    seed_vec[1] = '1;
    seed_vec[2] = 64'hAAAA_AAAA_AAAA_AAAA;
    seed_vec[3] = 64'h5555_5555_5555_5555;
    seed_vec[4] = 64'h0000_0000_0000_0001;
    seed_vec[5] = 64'h8000_0000_0000_0000;
    configure(7'd0, 5'd16);
    for (int s = 0; s < MaxEntries; s++) send_item(OP_LOAD, IdxW'(s), seed_vec[s]);
    send_item(OP_EVAL, 4'd0, '0);
    send_item(OP_EVAL, 4'd15, '1);
    send_item(OP_EVAL, 4'd3, 64'h5555_5555_5555_5555);
    send_item(OP_EVAL, 4'd9, seed_vec[9]);  // exact match at radius zero
    drain();
    configure(7'd64, 5'd16);                // radius equal to the full width
    send_item(OP_EVAL, 4'd0, '1);
    send_item(OP_EVAL, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_EVAL, 4'd0, 64'h8000_0000_0000_0001);

    // random phases over a spread of settings
    run_phase(RadW'($urandom_range(24, 40)), 5'd16, 48, 1'b1);  // receiver backs up the pipe
    run_phase(7'd127, 5'd31, 48, 1'b0);                         // radius past width, count saturates
    run_phase(7'd0, 5'd1, 48, 1'b0);
    run_phase(RadW'($urandom_range(0, 64)), 5'd0, 48, 1'b0);    // evals give nothing
    run_phase(7'd64, 5'd16, 48, 1'b0);
    run_phase(RadW'($urandom_range(0, 127)), CntW'($urandom_range(1, 16)), 48, 1'b0);
    run_phase(RadW'($urandom_range(0, 12)), CntW'($urandom_range(17, 31)), 48, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.pending_compares.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
